// File: rtl/cnf_dimacs_tokenizer_assert.svh
// Assertion macros shared by the tokenizer modules.
`ifndef CNF_DIMACS_TOKENIZER_ASSERT_SVH
`define CNF_DIMACS_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CNFDT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CNFDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cnfdt_pkg.sv
package cnfdt_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int FIFO_DEPTH     = 4;

  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;

  typedef enum logic [1:0] {
    KIND_LIT  = 2'd0,
    KIND_CAND = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       at_end;
  } char_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
    logic [30:0]        largest_var;
    logic               last;
  } tok_t;

  // Results of one character: up to two, the first always in r0.
  typedef struct packed {
    logic first;
    logic second;
    tok_t r0;
    tok_t r1;
  } push_t;

  function automatic tok_t make_tok(kind_t kind, logic signed [31:0] value,
                                    logic [30:0] largest, logic last);
    tok_t t;
    t.kind        = kind;
    t.value       = value;
    t.largest_var = largest;
    t.last        = last;
    return t;
  endfunction

endpackage

// File: rtl/cnfdt_scan.sv
`include "cnf_dimacs_tokenizer_assert.svh"

module cnfdt_scan #(
  parameter int VALUE_BITS = cnfdt_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  cnfdt_pkg::char_t  beat,
  output cnfdt_pkg::push_t  push
);

  localparam int EXT = VALUE_BITS + 32;
  localparam logic [VALUE_BITS-1:0] VAL_MAX = '1;

  typedef enum logic [3:0] {
    M_SCAN, M_NUMBER, M_AFTER, M_PFX_I, M_PFX_P, M_PFX_SP, M_SKIP, M_VIP
  } mode_t;

  mode_t                 mode, mode_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic                  negative, negative_next;
  logic [VALUE_BITS-1:0] max_seen, max_seen_next;

  logic [3:0]            digit;
  logic                  is_digit;
  logic [VALUE_BITS+3:0] acc_wide;
  logic [VALUE_BITS+3:0] acc_x10d;
  logic [VALUE_BITS-1:0] acc_sat;
  logic [VALUE_BITS-1:0] lit_max;
  logic [7:0]            ch;

  function automatic logic signed [31:0] to_value(logic [VALUE_BITS-1:0] mag, logic neg);
    logic [EXT-1:0] w;
    w = {32'b0, mag};
    if (neg) begin
      w = -w;
    end
    return w[31:0];
  endfunction

  function automatic logic [30:0] to_largest(logic [VALUE_BITS-1:0] m);
    logic [EXT-1:0] w;
    w = {32'b0, m};
    return w[30:0];
  endfunction

  // Step through "vip "; a newline ends the line, anything else skips it.
  function automatic mode_t prefix(logic [7:0] c, logic [7:0] want, mode_t nxt);
    mode_t m;
    if (c == want) begin
      m = nxt;
    end else if (c == cnfdt_pkg::CH_NL) begin
      m = M_SCAN;
    end else begin
      m = M_SKIP;
    end
    return m;
  endfunction

  assign ch       = beat.byte_req;
  assign digit    = 4'(ch - cnfdt_pkg::CH_0);
  assign is_digit = ch inside {[cnfdt_pkg::CH_0:cnfdt_pkg::CH_9]};
  assign acc_wide = {4'b0, acc};
  assign acc_x10d = (acc_wide << 3) + (acc_wide << 1) + (VALUE_BITS + 4)'(digit);
  assign acc_sat  = (acc_x10d > {4'b0, VAL_MAX}) ? VAL_MAX : acc_x10d[VALUE_BITS-1:0];
  assign lit_max  = (acc > max_seen) ? acc : max_seen;

  always_comb begin
    mode_next     = mode;
    acc_next      = acc;
    negative_next = negative;
    max_seen_next = max_seen;
    push          = '0;
    if (take) begin
      if (beat.at_end) begin
        mode_next     = M_SCAN;
        acc_next      = '0;
        negative_next = 1'b0;
        max_seen_next = '0;
        push.first    = 1'b1;
        case (mode)
          M_NUMBER: begin
            push.second = 1'b1;
            push.r0 = cnfdt_pkg::make_tok(cnfdt_pkg::KIND_LIT, to_value(acc, negative),
                                          to_largest(lit_max), 1'b0);
            push.r1 = cnfdt_pkg::make_tok(cnfdt_pkg::KIND_END, 32'sd0,
                                          to_largest(lit_max), 1'b1);
          end
          M_VIP: begin
            push.second = 1'b1;
            push.r0 = cnfdt_pkg::make_tok(cnfdt_pkg::KIND_CAND, to_value(acc, 1'b0),
                                          to_largest(max_seen), 1'b0);
            push.r1 = cnfdt_pkg::make_tok(cnfdt_pkg::KIND_END, 32'sd0,
                                          to_largest(max_seen), 1'b1);
          end
          default: begin
            push.r0 = cnfdt_pkg::make_tok(cnfdt_pkg::KIND_END, 32'sd0,
                                          to_largest(max_seen), 1'b1);
          end
        endcase
      end else begin
        case (mode)
          M_NUMBER: begin
            if (is_digit) begin
              acc_next = acc_sat;
            end else begin
              // Terminator is consumed without a look; the literal it closes is pushed.
              push.first    = 1'b1;
              push.r0       = cnfdt_pkg::make_tok(cnfdt_pkg::KIND_LIT,
                                                  to_value(acc, negative),
                                                  to_largest(lit_max), 1'b1);
              max_seen_next = lit_max;
              negative_next = 1'b0;
              acc_next      = '0;
              mode_next     = M_SCAN;
            end
          end
          M_AFTER:  mode_next = prefix(ch, cnfdt_pkg::CH_V, M_PFX_I);
          M_PFX_I:  mode_next = prefix(ch, cnfdt_pkg::CH_I, M_PFX_P);
          M_PFX_P:  mode_next = prefix(ch, cnfdt_pkg::CH_P, M_PFX_SP);
          M_PFX_SP: begin
            mode_next = prefix(ch, cnfdt_pkg::CH_SP, M_VIP);
            acc_next  = '0;
          end
          M_SKIP: begin
            if (ch == cnfdt_pkg::CH_NL) begin
              mode_next = M_SCAN;
            end
          end
          M_VIP: begin
            if (is_digit) begin
              acc_next = acc_sat;
            end else begin
              push.first = 1'b1;
              push.r0    = cnfdt_pkg::make_tok(cnfdt_pkg::KIND_CAND, to_value(acc, 1'b0),
                                               to_largest(max_seen), 1'b1);
              acc_next   = '0;
              if (ch == cnfdt_pkg::CH_NL) begin
                mode_next = M_SCAN;
              end
            end
          end
          default: begin
            if (ch == cnfdt_pkg::CH_C || ch == cnfdt_pkg::CH_P) begin
              mode_next = M_AFTER;
            end else if (ch == cnfdt_pkg::CH_MINUS) begin
              negative_next = 1'b1;
            end else if (is_digit) begin
              acc_next  = VALUE_BITS'(digit);
              mode_next = M_NUMBER;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_SCAN;
      acc      <= '0;
      negative <= 1'b0;
      max_seen <= '0;
    end else begin
      mode     <= mode_next;
      acc      <= acc_next;
      negative <= negative_next;
      max_seen <= max_seen_next;
    end
  end

  `CNFDT_ASSERT_NEXT(a_end_clears, clk, rst, take && beat.at_end,
    mode == M_SCAN && acc == '0 && !negative && max_seen == '0,
    "state not cleared after end of input")
  `CNFDT_ASSERT_IMPL(a_pair_ends, clk, rst, push.second,
    push.first && push.r1.kind == cnfdt_pkg::KIND_END && push.r1.last && !push.r0.last,
    "second result is not a final end marker")
  `CNFDT_ASSERT_IMPL(a_single_last, clk, rst, push.first && !push.second, push.r0.last,
    "single result not marked last")

endmodule

// File: rtl/cnfdt_rfifo.sv
`include "cnf_dimacs_tokenizer_assert.svh"

module cnfdt_rfifo (
  input  logic             clk,
  input  logic             rst,
  input  cnfdt_pkg::push_t push,
  output logic             room,
  input  logic             pop,
  output logic             tok_valid,
  output cnfdt_pkg::tok_t  tok_beat
);

  localparam int DEPTH = cnfdt_pkg::FIFO_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  cnfdt_pkg::tok_t slots [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count, count_next;
  logic [AW-1:0]   wr_ptr1;
  logic [1:0]      n_push;

  assign wr_ptr1   = wr_ptr + AW'(1);
  assign n_push    = {1'b0, push.first} + {1'b0, push.second};
  assign room      = count <= CW'(DEPTH - 2);
  assign tok_valid = count != '0;
  assign tok_beat  = slots[rd_ptr];
  assign count_next = count + CW'(n_push) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push.first) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.second) begin
      slots[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count_next;
    end
  end

  `CNFDT_ASSERT_NEXT(a_push_shows, clk, rst, push.first && !pop, tok_valid,
    "pushed result not visible")

endmodule

// File: rtl/cnf_dimacs_tokenizer.sv
// Channel  Beat type          Handshake               Direction
// char     cnfdt_pkg::char_t  char_valid/char_stall   text byte or end mark in
// tok      cnfdt_pkg::tok_t   tok_valid/tok_stall     literal, candidate, end out
//
// One character per cycle while char_stall is low: a beat is registered, decoded once
// the queue has room, and its results land in a four-entry result queue that feeds tok.
// An end mark gives up to two results; they leave one per cycle unless tok_stall.
// char_stall rises only while a registered beat waits for two free queue slots.
// rst is synchronous and returns the scanner to the start of a new formula.
`include "cnf_dimacs_tokenizer_assert.svh"

module cnf_dimacs_tokenizer #(
  parameter int VALUE_BITS = cnfdt_pkg::VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             char_valid,
  output logic             char_stall,
  input  cnfdt_pkg::char_t char_beat,
  output logic             tok_valid,
  input  logic             tok_stall,
  output cnfdt_pkg::tok_t  tok_beat
);

  cnfdt_pkg::char_t cur;
  logic             cur_valid;
  logic             room;
  logic             advance;
  logic             pop;
  cnfdt_pkg::push_t push;

  assign advance    = cur_valid && room;
  assign char_stall = cur_valid && !room;
  assign pop        = tok_valid && !tok_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (!char_stall) begin
      cur_valid <= char_valid;
    end
  end

  // Hold the beat while the queue has fewer than two free slots.
  always_ff @(posedge clk) begin
    if (!char_stall && char_valid) begin
      cur <= char_beat;
    end
  end

  cnfdt_scan #(
    .VALUE_BITS(VALUE_BITS)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .take (advance),
    .beat (cur),
    .push (push)
  );

  cnfdt_rfifo u_rfifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .pop       (pop),
    .tok_valid (tok_valid),
    .tok_beat  (tok_beat)
  );

  `CNFDT_ASSERT_NEXT(a_stall_holds, clk, rst, char_stall, cur_valid,
    "held beat lost during stall")

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cnfdt_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam logic [63:0] MAG_MAX = (64'd1 << VALUE_BITS_DEF) - 64'd1;

  typedef enum {
    ST_SCAN, ST_NUMBER, ST_AFTER_CP, ST_WANT_I, ST_WANT_P, ST_WANT_SP, ST_SKIP, ST_CAND
  } scan_state_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  char_valid = 1'b0;
  logic  char_stall;
  char_t char_beat = '0;
  logic  tok_valid;
  logic  tok_stall = 1'b0;
  tok_t  tok_beat;

  cnf_dimacs_tokenizer u_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_beat  (char_beat),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_beat   (tok_beat)
  );

  // Tokenizer state as the text predicts it.
  scan_state_t scan_st = ST_SCAN;
  logic [63:0] digit_acc = '0;
  bit          sign_pending = 1'b0;
  logic [63:0] widest_var = '0;
  tok_t        expected_toks[$];

  bit  gaps_on = 1'b1;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_len = 0;
  int  hold_left = 0;
  int  cycles = 0;
  int  errors = 0;
  int  chars_sent = 0;
  int  toks_checked = 0;
  int  kind_seen[3] = '{0, 0, 0};
  int  stalled_cycles = 0;
  tok_t want_tok;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold when a test asks for one.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      tok_stall <= 1'b1;
    end else begin
      tok_stall <= gaps_on && ($urandom_range(99) < 13);
    end
  end

  task automatic report_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && char_valid && char_stall) stalled_cycles++;
    if (!rst && tok_valid && !tok_stall) begin
      if (expected_toks.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none got kind %0d value %0d", $time,
                 tok_beat.kind, tok_beat.value);
      end else begin
        want_tok = expected_toks.pop_front();
        report_field("kind", want_tok.kind, tok_beat.kind);
        report_field("value", want_tok.value[31:0], tok_beat.value[31:0]);
        report_field("largest_var", want_tok.largest_var, tok_beat.largest_var);
        report_field("last", want_tok.last, tok_beat.last);
        toks_checked++;
        if (want_tok.kind <= KIND_END) kind_seen[want_tok.kind]++;
      end
    end
  end

  function automatic bit is_digit(logic [7:0] ch);
    return ch >= CH_0 && ch <= CH_9;
  endfunction

  function automatic logic [63:0] add_digit(logic [63:0] acc, logic [7:0] ch);
    logic [63:0] d;
    d = 64'(ch - CH_0);
    if (acc > (MAG_MAX - d) / 64'd10) return MAG_MAX;
    return acc * 64'd10 + d;
  endfunction

  function automatic scan_state_t prefix_next(logic [7:0] ch, logic [7:0] want,
                                              scan_state_t nxt);
    if (ch == want) return nxt;
    if (ch == CH_NL) return ST_SCAN;
    return ST_SKIP;
  endfunction

  task automatic push_tok(input kind_t kind, input logic [63:0] val, input logic last);
    tok_t t;
    t.kind        = kind;
    t.value       = val[31:0];
    t.largest_var = widest_var[30:0];
    t.last        = last;
    expected_toks.insert(expected_toks.size(), t);
  endtask

  task automatic close_literal(input logic last);
    if (digit_acc > widest_var) widest_var = digit_acc;
    push_tok(KIND_LIT, sign_pending ? 64'd0 - digit_acc : digit_acc, last);
    sign_pending = 1'b0;
    digit_acc    = '0;
  endtask

  task automatic scan_char(input logic [7:0] ch, input bit eoi);
    if (eoi) begin
      if (scan_st == ST_NUMBER) close_literal(1'b0);
      else if (scan_st == ST_CAND) push_tok(KIND_CAND, digit_acc, 1'b0);
      push_tok(KIND_END, 64'd0, 1'b1);
      scan_st      = ST_SCAN;
      digit_acc    = '0;
      sign_pending = 1'b0;
      widest_var   = '0;
      return;
    end
    case (scan_st)
      ST_NUMBER: begin
        if (is_digit(ch)) begin
          digit_acc = add_digit(digit_acc, ch);
        end else begin
          // the terminating character is consumed without a look
          close_literal(1'b1);
          scan_st = ST_SCAN;
        end
      end
      ST_AFTER_CP: scan_st = prefix_next(ch, CH_V, ST_WANT_I);
      ST_WANT_I:   scan_st = prefix_next(ch, CH_I, ST_WANT_P);
      ST_WANT_P:   scan_st = prefix_next(ch, CH_P, ST_WANT_SP);
      ST_WANT_SP: begin
        scan_st   = prefix_next(ch, CH_SP, ST_CAND);
        digit_acc = '0;
      end
      ST_SKIP: if (ch == CH_NL) scan_st = ST_SCAN;
      ST_CAND: begin
        if (is_digit(ch)) begin
          digit_acc = add_digit(digit_acc, ch);
        end else begin
          push_tok(KIND_CAND, digit_acc, 1'b1);
          digit_acc = '0;
          if (ch == CH_NL) scan_st = ST_SCAN;
        end
      end
      default: begin
        if (ch == CH_C || ch == CH_P) begin
          scan_st = ST_AFTER_CP;
        end else if (ch == CH_MINUS) begin
          sign_pending = 1'b1;
        end else if (is_digit(ch)) begin
          digit_acc = 64'(ch - CH_0);
          scan_st   = ST_NUMBER;
        end
      end
    endcase
  endtask

  // Offer one beat and hold it until accepted; valid stays up for the next beat.
  task automatic put_char(input logic [7:0] ch, input bit eoi);
    while (gaps_on && $urandom_range(99) < 13) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid          <= 1'b1;
    char_beat.byte_req  <= ch;
    char_beat.at_end    <= eoi;
    do @(posedge clk); while (char_stall);
    scan_char(ch, eoi);
    chars_sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i], 1'b0);
  endtask

  task automatic put_number();
    int len;
    len = ($urandom_range(19) == 0) ? $urandom_range(12, 10) : $urandom_range(3, 1);
    repeat (len) put_char(CH_0 + 8'($urandom_range(9)), 1'b0);
  endtask

  function automatic logic [7:0] rand_nondigit(bit allow_nl);
    logic [7:0] c;
    if ($urandom_range(3) != 0) return CH_SP;
    do c = 8'($urandom_range(255)); while (is_digit(c) || (!allow_nl && c == CH_NL));
    return c;
  endfunction

  task automatic put_text_line();
    int pick;
    int cut;
    string vip;
    vip  = "vip ";
    pick = $urandom_range(99);
    if (pick < 40) begin
      repeat ($urandom_range(4, 1)) begin
        if ($urandom_range(3) == 0) put_char(CH_MINUS, 1'b0);
        put_number();
        put_char(rand_nondigit(1'b0), 1'b0);
      end
      put_text("0\n");
    end else if (pick < 50) begin
      put_char(CH_C, 1'b0);
      repeat ($urandom_range(6)) put_char(rand_nondigit(1'b0), 1'b0);
      put_char(CH_NL, 1'b0);
    end else if (pick < 55) begin
      put_text("p cnf ");
      put_number();
      put_char(CH_SP, 1'b0);
      put_number();
      put_char(CH_NL, 1'b0);
    end else if (pick < 70) begin
      put_char($urandom_range(1) ? CH_C : CH_P, 1'b0);
      put_text(vip);
      repeat ($urandom_range(3)) begin
        if ($urandom_range(3) != 0) put_number();
        put_char(rand_nondigit(1'b0), 1'b0);
      end
      if ($urandom_range(1)) put_number();
      if ($urandom_range(4) == 0) put_char(8'($urandom_range(255)), 1'b1);
      else put_char(CH_NL, 1'b0);
    end else if (pick < 78) begin
      // break the prefix at a random point
      put_char($urandom_range(1) ? CH_C : CH_P, 1'b0);
      cut = $urandom_range(3);
      for (int i = 0; i < cut; i++) put_char(vip[i], 1'b0);
      put_char(8'($urandom_range(255)), 1'b0);
      put_char(CH_NL, 1'b0);
    end else if (pick < 88) begin
      repeat ($urandom_range(4, 1)) put_char(8'($urandom_range(255)), 1'b0);
    end else if (pick < 94) begin
      put_char(CH_MINUS, 1'b0);
      put_char(8'($urandom_range(255)), 1'b0);
    end else begin
      put_char(8'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic test_literals();
    // saturates to the widest magnitude, negated
    put_text("-9999999999");
    put_char(8'hFF, 1'b0);
    // end mark inside a literal
    put_char(CH_0 + 8'd3, 1'b0);
    put_char(8'h00, 1'b1);
  endtask

  task automatic test_lines();
    // a pending sign survives a candidate line
    put_char(CH_MINUS, 1'b0);
    put_text("cvip 1-\n");
    put_text("2 ");
    // newline inside the prefix ends the line
    put_text("p\n");
    put_char(8'h00, 1'b1);
  endtask

  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_len = 80;
    hold_req++;
    put_text("1 2 3 4 5 6 7 8 9 10 11 12 ");
    gaps_on = 1'b1;
  endtask

  task automatic test_random_text(input int count, input bit with_gaps);
    int stop;
    stop    = chars_sent + count;
    gaps_on = with_gaps;
    while (chars_sent < stop) put_text_line();
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_literals();
    test_lines();
    test_backpressure();
    test_random_text(120, 1'b0);
    test_random_text(380, 1'b1);
    put_char(8'($urandom_range(255)), 1'b1);
    char_valid <= 1'b0;
    while (expected_toks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("tb: %0d chars in, %0d tokens checked (%0d literals, %0d candidates, %0d ends)",
             chars_sent, toks_checked, kind_seen[0], kind_seen[1], kind_seen[2]);
    $display("tb: input held off for %0d cycles, %0d mismatches", stalled_cycles, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
